// ===== rtl/core/grmc_pkg.sv =====
// grmc_pkg: shared constants, types and elaboration-time tables of the column ray marcher
`default_nettype none

package grmc_pkg;

    // map and screen geometry
    localparam int MAP_W      = 32;
    localparam int MAP_H      = 16;
    localparam int VIEW_ROWS  = 40;
    localparam int VIEW_COLS  = 120;
    localparam int MAX_STEPS  = 160;

    // field widths
    localparam int POS_X_W    = 13;
    localparam int POS_Y_W    = 12;
    localparam int ANG_W      = 12;
    localparam int COL_W      = 7;
    localparam int STEP_W     = 8;
    localparam int CEIL_W     = 10;
    localparam int FLOOR_W    = 9;
    localparam int SHADE_W    = 3;
    localparam int KIND_W     = 2;

    // map register file: two 32-bit rows per 64-bit register
    localparam int CFG_REGS     = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ROW_BITS = 32;

    // angles, 4096 units per turn
    localparam int FOV          = 512;
    localparam int HALF_FOV     = FOV / 2;
    localparam int QUARTER_TURN = 1024;

    // quarter-wave sine table, Q1.14
    localparam int SIN_MAG_W   = 15;
    localparam int SIN_W       = SIN_MAG_W + 1;
    localparam int SIN_ONE     = 16384;
    localparam int QSIN_DEPTH  = QUARTER_TURN + 1;
    localparam int QSIN_IDX_W  = $clog2(QSIN_DEPTH);
    localparam longint PI_Q30  = 64'sd3373259426;

    // probe coordinates in 1/163840 cell: position*640 + direction*k
    localparam int     POS_SCALE      = 640;
    localparam int     STEPS_PER_CELL = 10;
    localparam int     CELL_SHIFT     = 15;
    localparam int     CELL_ODD       = 5;
    localparam longint CELL_UNITS     = 64'sd163840;
    localparam longint POS_SPAN_MAX   = longint'((2 ** POS_X_W) - 1) * POS_SCALE;
    localparam int     N_W = $clog2(POS_SPAN_MAX + longint'(SIN_ONE) * MAX_STEPS + 1) + 1;

    // cell index = (probe >> CELL_SHIFT) / CELL_ODD through a small table
    localparam int MAP_MAX   = (MAP_W > MAP_H) ? MAP_W : MAP_H;
    localparam int DIV_DEPTH = MAP_MAX * CELL_ODD;
    localparam int DIV_IDX_W = $clog2(DIV_DEPTH);
    localparam int CELL_W    = $clog2(MAP_MAX);
    localparam int CX_W      = $clog2(MAP_W);
    localparam int CY_W      = (MAP_H > 1) ? $clog2(MAP_H) : 1;

    // step counter and ceiling table
    localparam int K_W        = $clog2(MAX_STEPS + 1);
    localparam int CEIL_DEPTH = 2 ** K_W;

    // shade thresholds on the step count
    localparam int SHADE0_MAX = MAX_STEPS / 4;
    localparam int SHADE1_MAX = (MAX_STEPS - 1) / 3;
    localparam int SHADE2_MAX = (MAX_STEPS - 1) / 2;
    localparam int SHADE3_MAX = MAX_STEPS - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIN_X,
        ST_SIN_Y,
        ST_LOAD,
        ST_MARCH,
        ST_DONE
    } t_state;

    typedef enum logic [KIND_W-1:0] {
        END_HIT   = 2'd0,
        END_LEFT  = 2'd1,
        END_LIMIT = 2'd2
    } t_end_kind;

    typedef enum logic [SHADE_W-1:0] {
        SHADE_FULL   = 3'd0,
        SHADE_DARK   = 3'd1,
        SHADE_MEDIUM = 3'd2,
        SHADE_LIGHT  = 3'd3,
        SHADE_NONE   = 3'd4
    } t_shade;

    // sequencer to march unit
    typedef struct packed {
        logic ld_dx;
        logic load;
        logic advance;
    } t_march_ctrl;

    // march unit to sequencer
    typedef struct packed {
        logic off_map;
        logic wall;
        logic last;
    } t_march_stat;

    typedef logic [SIN_MAG_W-1:0]     t_qsin_rom [QSIN_DEPTH];
    typedef logic [CELL_W-1:0]        t_div_tab  [DIV_DEPTH];
    typedef logic signed [CEIL_W-1:0] t_ceil_tab [CEIL_DEPTH];
    typedef logic [ANG_W-1:0]         t_col_tab  [2 ** COL_W];

    // restoring unsigned division, table building only
    function automatic longint unsigned f_udiv(longint unsigned n, longint unsigned d);
        longint unsigned rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= d) begin
                rem    = rem - d;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // taylor series of sin(a*pi/2048) in Q30, rounded to Q14
    function automatic longint f_quarter_sine(int a);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        logic            neg;
        x    = (longint'(a) * PI_Q30) >> 11;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        neg  = 1'b1;
        for (int k = 2; k <= 14; k += 2) begin
            term = f_udiv((term * x2) >> 30, longint'(k * (k + 1)));
            sum  = neg ? sum - longint'(term) : sum + longint'(term);
            neg  = !neg;
        end
        if (sum < 0) begin
            sum = 0;
        end
        return (sum + 32768) >>> 16;
    endfunction

    function automatic t_qsin_rom f_qsin_rom();
        t_qsin_rom tab;
        for (int a = 0; a < QSIN_DEPTH; a++) begin
            tab[a] = SIN_MAG_W'(f_quarter_sine(a));
        end
        return tab;
    endfunction

    function automatic t_div_tab f_div_tab();
        t_div_tab tab;
        for (int i = 0; i < DIV_DEPTH; i++) begin
            tab[i] = CELL_W'(f_udiv(longint'(i), longint'(CELL_ODD)));
        end
        return tab;
    endfunction

    // ceiling row trunc((rows*s - 2*10*rows) / (2*s)), toward zero
    function automatic t_ceil_tab f_ceil_tab();
        t_ceil_tab tab;
        longint    num;
        longint    den;
        longint    quo;
        for (int s = 0; s < CEIL_DEPTH; s++) begin
            if (s == 0) begin
                tab[s] = '0;
            end else begin
                num = longint'(VIEW_ROWS) * s - longint'(2 * STEPS_PER_CELL * VIEW_ROWS);
                den = 2 * longint'(s);
                if (num >= 0) begin
                    quo = longint'(f_udiv(num, den));
                end else begin
                    quo = -longint'(f_udiv(-num, den));
                end
                tab[s] = CEIL_W'(quo);
            end
        end
        return tab;
    endfunction

    // angle offset of each screen column, floor(col*FOV/VIEW_COLS) mod turn
    function automatic t_col_tab f_col_tab();
        t_col_tab tab;
        for (int c = 0; c < 2 ** COL_W; c++) begin
            tab[c] = ANG_W'(f_udiv(longint'(c) * FOV, longint'(VIEW_COLS)));
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/grid_ray_march_column_core.sv =====
// grid_ray_march_column_core: casts one column ray over the wall map and reports the slice
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+-------------------------------------------
//  request  | in  | i_in_valid / o_in_stall   | i_pos_x, i_pos_y, i_view_angle, i_column
//  result   | out | o_out_valid / i_out_stall | o_step_count, o_ceiling_row, o_floor_row,
//           |     |                           | o_wall_shade, o_end_kind
//  config   | in  | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
//  after acceptance the sequencer steps through ST_SIN_X, ST_SIN_Y, ST_LOAD, then ST_MARCH
//  for k = 1..160 march steps and ST_DONE; the next request is taken back in ST_IDLE.
//  the march loop tests one probe per cycle in the march unit.
//  o_in_stall is high from acceptance until the result is loaded into the output register.
//  a stalled result does not block acceptance, but holds the next one in ST_DONE.
//  synchronous active-low reset clears the sequencer, output valid and the map registers.
`default_nettype none

module grid_ray_march_column_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [grmc_pkg::POS_X_W-1:0]         i_pos_x,
    input  wire logic [grmc_pkg::POS_Y_W-1:0]         i_pos_y,
    input  wire logic [grmc_pkg::ANG_W-1:0]           i_view_angle,
    input  wire logic [grmc_pkg::COL_W-1:0]           i_column,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [grmc_pkg::STEP_W-1:0]               o_step_count,
    output logic signed [grmc_pkg::CEIL_W-1:0]        o_ceiling_row,
    output logic [grmc_pkg::FLOOR_W-1:0]              o_floor_row,
    output logic [grmc_pkg::SHADE_W-1:0]              o_wall_shade,
    output logic [grmc_pkg::KIND_W-1:0]               o_end_kind,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [grmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [grmc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import grmc_pkg::*;

    localparam t_col_tab  COL_TAB  = f_col_tab();
    localparam t_ceil_tab CEIL_TAB = f_ceil_tab();

    t_state                  r_state;
    t_state                  n_state;
    logic [POS_X_W-1:0]      r_px;
    logic [POS_Y_W-1:0]      r_py;
    logic [ANG_W-1:0]        r_ray;
    logic [K_W-1:0]          r_steps;
    logic [K_W-1:0]          n_steps;
    t_end_kind               r_kind;
    t_end_kind               n_kind;

    logic                    r_out_valid;
    logic [STEP_W-1:0]       r_step_count;
    logic signed [CEIL_W-1:0] r_ceil;
    logic [FLOOR_W-1:0]      r_floor;
    t_shade                  r_shade;
    t_end_kind               r_end_kind;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_load_out;
    logic [ANG_W-1:0]        w_ray;
    logic [ANG_W-1:0]        w_sin_angle;
    logic signed [SIN_W-1:0] w_sine;
    t_march_ctrl             w_ctrl;
    t_march_stat             w_stat;
    logic [K_W-1:0]          w_k;
    logic signed [CEIL_W-1:0] w_ceil;
    logic signed [CEIL_W:0]  w_floor_full;
    t_shade                  w_shade;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ray angle of the column
    assign w_ray = i_view_angle + COL_TAB[i_column] - ANG_W'(HALF_FOV);

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_ray <= w_ray;
        end
    end

    // sine for x, then cosine for y
    assign w_sin_angle = (r_state == ST_SIN_Y) ? r_ray + ANG_W'(QUARTER_TURN) : r_ray;

    grmc_sine_rom u_sine (
        .i_clk   (i_clk),
        .i_angle (w_sin_angle),
        .o_sine  (w_sine)
    );

    grmc_march_unit u_march (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_pos_x     (r_px),
        .i_pos_y     (r_py),
        .i_sine      (w_sine),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_step      (w_k)
    );

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps <= n_steps;
        r_kind  <= n_kind;
    end

    // sequencer next state and step control
    always_comb begin
        n_state        = r_state;
        n_steps        = r_steps;
        n_kind         = r_kind;
        w_ctrl         = '0;
        w_load_out     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_SIN_X;
                end
            end
            ST_SIN_X: begin
                n_state = ST_SIN_Y;
            end
            ST_SIN_Y: begin
                w_ctrl.ld_dx = 1'b1;
                n_state      = ST_LOAD;
            end
            ST_LOAD: begin
                w_ctrl.load = 1'b1;
                n_state     = ST_MARCH;
            end
            ST_MARCH: begin
                priority if (w_stat.off_map) begin
                    n_steps = K_W'(MAX_STEPS);
                    n_kind  = END_LEFT;
                    n_state = ST_DONE;
                end else if (w_stat.wall) begin
                    n_steps = w_k;
                    n_kind  = END_HIT;
                    n_state = ST_DONE;
                end else if (w_stat.last) begin
                    n_steps = K_W'(MAX_STEPS);
                    n_kind  = END_LIMIT;
                    n_state = ST_DONE;
                end else begin
                    w_ctrl.advance = 1'b1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // slice rows and shade from the step count
    assign w_ceil       = CEIL_TAB[r_steps];
    assign w_floor_full = (CEIL_W + 1)'(VIEW_ROWS) - {w_ceil[CEIL_W-1], w_ceil};

    always_comb begin
        priority if (r_steps <= K_W'(SHADE0_MAX)) begin
            w_shade = SHADE_FULL;
        end else if (r_steps <= K_W'(SHADE1_MAX)) begin
            w_shade = SHADE_DARK;
        end else if (r_steps <= K_W'(SHADE2_MAX)) begin
            w_shade = SHADE_MEDIUM;
        end else if (r_steps <= K_W'(SHADE3_MAX)) begin
            w_shade = SHADE_LIGHT;
        end else begin
            w_shade = SHADE_NONE;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_step_count <= STEP_W'(r_steps);
            r_ceil       <= w_ceil;
            r_floor      <= w_floor_full[FLOOR_W-1:0];
            r_shade      <= w_shade;
            r_end_kind   <= r_kind;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step_count  = r_step_count;
    assign o_ceiling_row = r_ceil;
    assign o_floor_row   = r_floor;
    assign o_wall_shade  = r_shade;
    assign o_end_kind    = r_end_kind;

endmodule

`default_nettype wire

// ===== rtl/core/grmc_sine_rom.sv =====
// grmc_sine_rom: quarter-wave sine rom with quadrant folding, one read per cycle
`default_nettype none

module grmc_sine_rom (
    input  wire logic                              i_clk,
    input  wire logic [grmc_pkg::ANG_W-1:0]        i_angle,
    output logic signed [grmc_pkg::SIN_W-1:0]      o_sine
);
    import grmc_pkg::*;

    localparam t_qsin_rom QSIN = f_qsin_rom();

    logic [1:0]              w_quad;
    logic [ANG_W-3:0]        w_frac;
    logic [QSIN_IDX_W-1:0]   w_addr;
    logic [SIN_MAG_W-1:0]    r_mag;
    logic                    r_neg;
    logic signed [SIN_W-1:0] w_pos;

    // fold the angle into the first quadrant
    always_comb begin
        w_quad = i_angle[ANG_W-1 -: 2];
        w_frac = i_angle[ANG_W-3:0];
        if (w_quad[0]) begin
            w_addr = QSIN_IDX_W'(QUARTER_TURN) - {1'b0, w_frac};
        end else begin
            w_addr = {1'b0, w_frac};
        end
    end

    // registered rom read
    always_ff @(posedge i_clk) begin
        r_mag <= QSIN[w_addr];
        r_neg <= w_quad[1];
    end

    // lower half-turn is negated
    assign w_pos  = signed'({1'b0, r_mag});
    assign o_sine = r_neg ? -w_pos : w_pos;

endmodule

`default_nettype wire

// ===== rtl/core/grmc_march_unit.sv =====
// grmc_march_unit: map registers, probe accumulators and the per-step cell test
`default_nettype none

module grmc_march_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire grmc_pkg::t_march_ctrl               i_ctrl,
    input  wire logic [grmc_pkg::POS_X_W-1:0]        i_pos_x,
    input  wire logic [grmc_pkg::POS_Y_W-1:0]        i_pos_y,
    input  wire logic signed [grmc_pkg::SIN_W-1:0]   i_sine,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [grmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [grmc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output grmc_pkg::t_march_stat                    o_stat,
    output logic [grmc_pkg::K_W-1:0]                 o_step
);
    import grmc_pkg::*;

    localparam t_div_tab DIV_TAB = f_div_tab();

    localparam logic signed [N_W-1:0] NEG_LIM = N_W'(-CELL_UNITS);
    localparam logic signed [N_W-1:0] X_LIM   = N_W'(longint'(MAP_W) * CELL_UNITS);
    localparam logic signed [N_W-1:0] Y_LIM   = N_W'(longint'(MAP_H) * CELL_UNITS);

    logic [CFG_DATA_W-1:0]   r_map [CFG_REGS];
    logic [MAP_W-1:0]        w_rows [MAP_H];
    logic signed [SIN_W-1:0] r_dx;
    logic signed [SIN_W-1:0] r_dy;
    logic signed [N_W-1:0]   r_nx;
    logic signed [N_W-1:0]   r_ny;
    logic [K_W-1:0]          r_k;

    logic signed [N_W-1:0]   w_dx_ext;
    logic signed [N_W-1:0]   w_dy_ext;
    logic signed [N_W-1:0]   w_sine_ext;
    logic signed [N_W-1:0]   w_base_x;
    logic signed [N_W-1:0]   w_base_y;
    logic                    w_x_off;
    logic                    w_y_off;
    logic [DIV_IDX_W-1:0]    w_x_idx;
    logic [DIV_IDX_W-1:0]    w_y_idx;
    logic [CELL_W-1:0]       w_x_q;
    logic [CELL_W-1:0]       w_y_q;
    logic [CX_W-1:0]         w_cx;
    logic [CY_W-1:0]         w_cy;

    // map register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '{default: '0};
        end else if (i_cfg_wr_en) begin
            r_map[i_cfg_index] <= i_cfg_data;
        end
    end

    // unpack rows: even rows in the low half, odd rows in the high half
    for (genvar r = 0; r < MAP_H; r++) begin : g_row
        assign w_rows[r] = r_map[r / 2][(r % 2) * CFG_ROW_BITS +: MAP_W];
    end

    // sign extension of directions and scaling of the start position
    assign w_dx_ext   = {{(N_W - SIN_W){r_dx[SIN_W-1]}}, r_dx};
    assign w_dy_ext   = {{(N_W - SIN_W){r_dy[SIN_W-1]}}, r_dy};
    assign w_sine_ext = {{(N_W - SIN_W){i_sine[SIN_W-1]}}, i_sine};
    assign w_base_x   = signed'((N_W'(i_pos_x) << 9) + (N_W'(i_pos_x) << 7));
    assign w_base_y   = signed'((N_W'(i_pos_y) << 9) + (N_W'(i_pos_y) << 7));

    // probe accumulators and step counter
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_dx) begin
            r_dx <= i_sine;
        end
        if (i_ctrl.load) begin
            r_dy <= i_sine;
            r_nx <= w_base_x + w_dx_ext;
            r_ny <= w_base_y + w_sine_ext;
        end else if (i_ctrl.advance) begin
            r_nx <= r_nx + w_dx_ext;
            r_ny <= r_ny + w_dy_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_ctrl.load) begin
            r_k <= K_W'(1);
        end else if (i_ctrl.advance) begin
            r_k <= r_k + K_W'(1);
        end
    end

    // cell of each probe coordinate, truncated toward zero
    always_comb begin
        w_x_off = (r_nx <= NEG_LIM) || (r_nx >= X_LIM);
        w_y_off = (r_ny <= NEG_LIM) || (r_ny >= Y_LIM);
        w_x_idx = r_nx[N_W-1] ? '0 : r_nx[CELL_SHIFT +: DIV_IDX_W];
        w_y_idx = r_ny[N_W-1] ? '0 : r_ny[CELL_SHIFT +: DIV_IDX_W];
        w_x_q   = DIV_TAB[w_x_idx];
        w_y_q   = DIV_TAB[w_y_idx];
        w_cx    = w_x_q[CX_W-1:0];
        w_cy    = w_y_q[CY_W-1:0];
    end

    // step status to the sequencer
    always_comb begin
        o_stat.off_map = w_x_off || w_y_off;
        o_stat.wall    = w_rows[w_cy][w_cx];
        o_stat.last    = (r_k == K_W'(MAX_STEPS));
    end

    assign o_step = r_k;

endmodule

`default_nettype wire

// ===== rtl/core/grmc_checker.sv =====
// grmc_checker: port-level assertions on the column ray marcher, bound to the top level
`default_nettype none

module grmc_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    input  wire logic                                 o_in_stall,
    input  wire logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    input  wire logic [grmc_pkg::STEP_W-1:0]          o_step_count,
    input  wire logic signed [grmc_pkg::CEIL_W-1:0]   o_ceiling_row,
    input  wire logic [grmc_pkg::FLOOR_W-1:0]         o_floor_row,
    input  wire logic [grmc_pkg::SHADE_W-1:0]         o_wall_shade,
    input  wire logic [grmc_pkg::KIND_W-1:0]          o_end_kind
);
    import grmc_pkg::*;

    logic                   w_in_acc;
    logic signed [CEIL_W:0] w_floor_full;

    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_floor_full = (CEIL_W + 1)'(VIEW_ROWS) - {o_ceiling_row[CEIL_W-1], o_ceiling_row};

    // a request always takes the sequencer out of idle
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("request accepted but block not busy next cycle");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_step_count) && $stable(o_ceiling_row)
             && $stable(o_end_kind)))
        else $error("stalled result changed");

    // floor row mirrors the ceiling row
    a_floor_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_floor_row == w_floor_full[FLOOR_W-1:0]))
        else $error("floor row does not match ceiling row");

    // leaving the map reports full depth and no shade
    a_left_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_end_kind == KIND_W'(END_LEFT))) |->
            ((o_step_count == STEP_W'(MAX_STEPS)) && (o_wall_shade == SHADE_W'(SHADE_NONE))))
        else $error("left-map result with wrong step count or shade");

    // step count stays within the march range
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_step_count != '0) && (o_step_count <= STEP_W'(MAX_STEPS))))
        else $error("step count out of range");

endmodule

bind grid_ray_march_column_core grmc_checker u_grmc_checker (.*);

`default_nettype wire

// ===== verif/grid_ray_march_column_core_test.sv =====
// grid_ray_march_column_core_test: self-checking bench for the column ray marcher
module grid_ray_march_column_core_test;
    import grmc_pkg::*;

    localparam int LIMIT_CYCLES  = 2000000;
    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_MAX    = 10;
    // directed wall cell: column 17 of row 8, held in the low half of register 4
    localparam int WALL_X        = 17;
    localparam int WALL_REG      = 4;
    localparam int ROW8_MID_Y    = 8 * 256 + 128;
    localparam int CENTRE_COL    = VIEW_COLS / 2;
    localparam int ANG_EAST      = QUARTER_TURN;
    localparam int ANG_WEST      = 3 * QUARTER_TURN;

    typedef struct {
        logic [STEP_W-1:0]        steps;
        logic signed [CEIL_W-1:0] ceil_row;
        logic [FLOOR_W-1:0]       floor_row;
        t_shade                   shade;
        t_end_kind                kind;
    } t_slice;

    typedef enum int {
        MAP_EMPTY,
        MAP_SPARSE,
        MAP_BORDER,
        MAP_DENSE,
        MAP_SOLID
    } t_map_style;

    // predicts the wall slice of each accepted request and checks the results in order
    class slice_scoreboard;
        logic [CFG_DATA_W-1:0] map_rows [CFG_REGS];
        longint                quarter_wave [QSIN_DEPTH];
        t_slice                expected_slices [$];
        int                    mismatches;

        // quarter-wave sine in Q1.14 from a truncated taylor series in Q30
        function new();
            longint x;
            longint x2;
            longint term;
            longint sum;
            bit     subtract;
            for (int a = 0; a < QSIN_DEPTH; a++) begin
                // half a turn is 2048 angle units
                x        = (longint'(a) * PI_Q30) / 2048;
                x2       = (x * x) >>> 30;
                term     = x;
                sum      = x;
                subtract = 1'b1;
                for (int k = 2; k <= 14; k += 2) begin
                    term     = ((term * x2) >>> 30) / longint'(k * (k + 1));
                    sum      = subtract ? sum - term : sum + term;
                    subtract = !subtract;
                end
                if (sum < 0) begin
                    sum = 0;
                end
                quarter_wave[a] = (sum + 32768) >>> 16;
            end
            foreach (map_rows[i]) begin
                map_rows[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void write_map(int idx, logic [CFG_DATA_W-1:0] data);
            if (idx < CFG_REGS) begin
                map_rows[idx] = data;
            end
        endfunction

        // full-turn sine by mirroring and negating the quarter wave
        function longint sine_q14(int ang);
            int     quad;
            int     rem;
            longint mag;
            quad = (ang >> 10) & 3;
            rem  = ang & (QUARTER_TURN - 1);
            mag  = (quad & 1) ? quarter_wave[QUARTER_TURN - rem] : quarter_wave[rem];
            return (quad & 2) ? -mag : mag;
        endfunction

        // truncation toward zero, so a small negative probe still lands in cell 0
        function int cell_index(longint n);
            if (n <= -CELL_UNITS) begin
                return -1;
            end
            if (n < 0) begin
                return 0;
            end
            return int'(n / CELL_UNITS);
        endfunction

        function t_slice predict_slice(logic [POS_X_W-1:0] px, logic [POS_Y_W-1:0] py,
                                       logic [ANG_W-1:0] view, logic [COL_W-1:0] col);
            t_slice s;
            int     ray;
            int     cx;
            int     cy;
            int     steps;
            longint dx;
            longint dy;
            longint num;
            longint den;
            longint ceil_row;
            bit     done;
            ray    = (int'(view) + 4096 - HALF_FOV + (int'(col) * FOV) / VIEW_COLS) & 4095;
            dx     = sine_q14(ray);
            dy     = sine_q14((ray + QUARTER_TURN) & 4095);
            steps  = MAX_STEPS;
            s.kind = END_LIMIT;
            done   = 1'b0;
            // march in tenths of a cell until a wall, the map edge or the depth limit
            for (int k = 1; k <= MAX_STEPS && !done; k++) begin
                cx = cell_index(longint'(px) * POS_SCALE + dx * k);
                cy = cell_index(longint'(py) * POS_SCALE + dy * k);
                if (cx < 0 || cx >= MAP_W || cy < 0 || cy >= MAP_H) begin
                    s.kind = END_LEFT;
                    steps  = MAX_STEPS;
                    done   = 1'b1;
                end else if (map_rows[cy >> 1][(cy & 1) * CFG_ROW_BITS + cx]) begin
                    s.kind = END_HIT;
                    steps  = k;
                    done   = 1'b1;
                end
            end
            // ceiling row rounded toward zero
            num         = longint'(VIEW_ROWS) * steps - 2 * STEPS_PER_CELL * VIEW_ROWS;
            den         = 2 * longint'(steps);
            ceil_row    = (num >= 0) ? num / den : -((-num) / den);
            s.steps     = STEP_W'(steps);
            s.ceil_row  = CEIL_W'(ceil_row);
            s.floor_row = FLOOR_W'(VIEW_ROWS - ceil_row);
            if (steps * 4 <= MAX_STEPS) begin
                s.shade = SHADE_FULL;
            end else if (steps * 3 < MAX_STEPS) begin
                s.shade = SHADE_DARK;
            end else if (steps * 2 < MAX_STEPS) begin
                s.shade = SHADE_MEDIUM;
            end else if (steps < MAX_STEPS) begin
                s.shade = SHADE_LIGHT;
            end else begin
                s.shade = SHADE_NONE;
            end
            return s;
        endfunction

        function void note_request(logic [POS_X_W-1:0] px, logic [POS_Y_W-1:0] py,
                                   logic [ANG_W-1:0] view, logic [COL_W-1:0] col);
            expected_slices.push_back(predict_slice(px, py, view, col));
        endfunction

        function void check_slice(logic [STEP_W-1:0] steps, logic signed [CEIL_W-1:0] ceil_row,
                                  logic [FLOOR_W-1:0] floor_row, logic [SHADE_W-1:0] shade,
                                  logic [KIND_W-1:0] kind);
            t_slice e;
            if (expected_slices.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected slice: steps %0d ceiling %0d floor %0d shade %0d end %0d",
                             steps, ceil_row, floor_row, shade, kind);
                end
                return;
            end
            e = expected_slices.pop_front();
            if (steps !== e.steps || ceil_row !== e.ceil_row || floor_row !== e.floor_row ||
                shade !== e.shade || kind !== e.kind) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("slice mismatch: expected steps %0d ceiling %0d floor %0d shade %0d end %0d",
                             e.steps, e.ceil_row, e.floor_row, e.shade, e.kind);
                    $display("                actual   steps %0d ceiling %0d floor %0d shade %0d end %0d",
                             steps, ceil_row, floor_row, shade, kind);
                end
            end
        endfunction
    endclass

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic [POS_X_W-1:0]         i_pos_x      = '0;
    logic [POS_Y_W-1:0]         i_pos_y      = '0;
    logic [ANG_W-1:0]           i_view_angle = '0;
    logic [COL_W-1:0]           i_column     = '0;
    logic                       i_out_stall  = 1'b0;
    logic                       i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data   = '0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [STEP_W-1:0]          o_step_count;
    logic signed [CEIL_W-1:0]   o_ceiling_row;
    logic [FLOOR_W-1:0]         o_floor_row;
    logic [SHADE_W-1:0]         o_wall_shade;
    logic [KIND_W-1:0]          o_end_kind;

    slice_scoreboard sb;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              cycle_count    = 0;

    grid_ray_march_column_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_view_angle  (i_view_angle),
        .i_column      (i_column),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_step_count  (o_step_count),
        .o_ceiling_row (o_ceiling_row),
        .o_floor_row   (o_floor_row),
        .o_wall_shade  (o_wall_shade),
        .o_end_kind    (o_end_kind),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_slice(o_step_count, o_ceiling_row, o_floor_row, o_wall_shade, o_end_kind);
        end
    end

    // one request with optional idle gaps ahead of it, held until accepted
    task automatic send_request(logic [POS_X_W-1:0] px, logic [POS_Y_W-1:0] py,
                                logic [ANG_W-1:0] view, logic [COL_W-1:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pos_x      <= px;
        i_pos_y      <= py;
        i_view_angle <= view;
        i_column     <= col;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_request(px, py, view, col);
        @(negedge i_clk);
    endtask

    // hold off until every outstanding slice has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_slices.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // one register per cycle; the caller lowers the write enable afterwards
    task automatic cfg_write(int idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_IDX_W'(idx);
        i_cfg_data  <= data;
        sb.write_map(idx, data);
        @(negedge i_clk);
    endtask

    task automatic load_map(t_map_style style);
        logic [CFG_ROW_BITS-1:0] rows [MAP_H];
        for (int r = 0; r < MAP_H; r++) begin
            case (style)
                MAP_EMPTY: begin
                    rows[r] = '0;
                end
                MAP_SPARSE: begin
                    rows[r] = $urandom & $urandom & $urandom;
                end
                MAP_BORDER: begin
                    if (r == 0 || r == MAP_H - 1) begin
                        rows[r] = '1;
                    end else begin
                        rows[r] = 32'h8000_0001 | ($urandom & $urandom & $urandom & $urandom);
                    end
                end
                MAP_DENSE: begin
                    rows[r] = $urandom;
                end
                default: begin
                    rows[r] = '1;
                end
            endcase
        end
        for (int i = 0; i < CFG_REGS; i++) begin
            cfg_write(i, {rows[2 * i + 1], rows[2 * i]});
        end
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // new map and idling mix, then random requests with the odd full drain
    task automatic run_phase(t_map_style style, int idle_pct, int stall_pct, int n_items);
        logic [POS_X_W-1:0] px;
        logic [POS_Y_W-1:0] py;
        logic [ANG_W-1:0]   view;
        logic [COL_W-1:0]   col;
        int                 pick;
        wait_drained();
        load_map(style);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) begin
            if ($urandom_range(149) == 0) begin
                wait_drained();
            end
            pick = $urandom_range(99);
            px   = POS_X_W'($urandom);
            py   = POS_Y_W'($urandom);
            view = ANG_W'($urandom);
            col  = COL_W'($urandom_range(VIEW_COLS - 1));
            if (pick < 8) begin
                // columns past the screen edge
                col = COL_W'($urandom_range(2 ** COL_W - 1, VIEW_COLS));
            end else if (pick < 14) begin
                px = $urandom_range(1) ? '0 : '1;
                py = $urandom_range(1) ? '0 : '1;
            end else if (pick < 20) begin
                // axis-aligned rays
                view = ANG_W'($urandom_range(3) * QUARTER_TURN);
                col  = COL_W'(CENTRE_COL);
            end
            send_request(px, py, view, col);
        end
    endtask

    initial begin
        int hit_steps [9] = '{1, 40, 41, 53, 54, 79, 80, 159, 160};
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty map after reset: field extremes, depth limit, leaving the map, angle wrap
        send_request('0, '0, '0, '0);
        send_request('1, '1, '1, '1);
        send_request(POS_X_W'(256), POS_Y_W'(2048), ANG_W'(ANG_EAST), COL_W'(CENTRE_COL));
        send_request('0, '0, ANG_W'(ANG_WEST), COL_W'(CENTRE_COL));
        send_request(POS_X_W'(4096), POS_Y_W'(2048), '0, COL_W'(VIEW_COLS));
        send_request(POS_X_W'(4096), POS_Y_W'(2048), ANG_W'(2048), COL_W'(VIEW_COLS - 1));

        // single wall cell: hits on chosen steps around each shade boundary and the last step
        wait_drained();
        cfg_write(WALL_REG, CFG_DATA_W'(1) << WALL_X);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        foreach (hit_steps[i]) begin
            send_request(POS_X_W'((WALL_X * int'(CELL_UNITS) - SIN_ONE * hit_steps[i]
                                   + POS_SCALE - 1) / POS_SCALE),
                         POS_Y_W'(ROW8_MID_Y), ANG_W'(ANG_EAST), COL_W'(CENTRE_COL));
        end
        // start inside the wall cell, marching further in and marching out
        send_request(POS_X_W'(WALL_X * 256 + 128), POS_Y_W'(ROW8_MID_Y), ANG_W'(ANG_EAST),
                     COL_W'(CENTRE_COL));
        send_request(POS_X_W'(WALL_X * 256 + 20), POS_Y_W'(ROW8_MID_Y), ANG_W'(ANG_WEST),
                     COL_W'(CENTRE_COL));

        // random phases over several maps and idling mixes
        run_phase(MAP_SPARSE, 0, 0, 370);
        run_phase(MAP_BORDER, 63, 0, 370);
        run_phase(MAP_SOLID, 0, 63, 370);
        run_phase(MAP_DENSE, 23, 23, 370);
        run_phase(MAP_EMPTY, 0, 0, 370);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.expected_slices.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/grmc_pkg.sv
rtl/core/grmc_sine_rom.sv
rtl/core/grmc_march_unit.sv
rtl/core/grid_ray_march_column_core.sv
rtl/core/grmc_checker.sv
verif/grid_ray_march_column_core_test.sv
